// ----- src/tgr_pkg.sv -----
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types, constants and the 5x7 font for the text glyph rasterizer.
// ----------------------------------------------------------------------------
package tgr_pkg;

    localparam int unsigned CODE_W       = 8;
    localparam int unsigned COORD_W      = 8;
    localparam int unsigned COLOR_W      = 16;
    localparam int unsigned GLYPH_COLS   = 5;
    localparam int unsigned GLYPH_ROWS   = 7;
    localparam int unsigned GLYPH_IDX_W  = 6;
    localparam int unsigned DEF_QUEUE_DEPTH = 2;

    localparam logic [COORD_W-1:0] ADVANCE    = 8'd6;
    localparam logic [COORD_W-1:0] LINE_STEP  = 8'd8;
    localparam logic [COORD_W-1:0] COL_LIMIT  = 8'd122;
    localparam logic [COORD_W-1:0] WIN_WIDTH  = 8'd4;
    localparam logic [COORD_W-1:0] WIN_HEIGHT = 8'd6;

    localparam logic [CODE_W-1:0] CMD_CASET = 8'h2A;
    localparam logic [CODE_W-1:0] CMD_RASET = 8'h2B;
    localparam logic [CODE_W-1:0] CMD_RAMWR = 8'h2C;

    localparam logic [CODE_W-1:0] CHAR_A    = 8'h41;
    localparam logic [CODE_W-1:0] CHAR_Z    = 8'h5A;
    localparam logic [CODE_W-1:0] CHAR_0    = 8'h30;
    localparam logic [CODE_W-1:0] CHAR_9    = 8'h39;
    localparam logic [GLYPH_IDX_W-1:0] DIGIT_BASE = 6'd27;

    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 1'b1;

    // column-major glyph: [column][row], row 0 is the top line
    typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

    // one character request handed from front to back
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        glyph_t             glyph;
    } char_req_t;

    function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
        logic [GLYPH_IDX_W-1:0] idx;
        idx = '0;
        if (code >= CHAR_A && code <= CHAR_Z) begin
            idx = GLYPH_IDX_W'(code - CHAR_A) + 6'd1;
        end else if (code >= CHAR_0 && code <= CHAR_9) begin
            idx = GLYPH_IDX_W'(code - CHAR_0) + DIGIT_BASE;
        end
        return idx;
    endfunction

    function automatic glyph_t glyph_rom(input logic [GLYPH_IDX_W-1:0] idx);
        logic [34:0] g;
        // columns listed left to right, column 0 in the top bits
        case (idx)
            6'd1:  g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
            6'd2:  g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
            6'd3:  g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
            6'd4:  g = {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
            6'd5:  g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
            6'd6:  g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h01};
            6'd7:  g = {7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A};
            6'd8:  g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
            6'd9:  g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
            6'd10: g = {7'h20, 7'h40, 7'h41, 7'h3F, 7'h01};
            6'd11: g = {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
            6'd12: g = {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
            6'd13: g = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
            6'd14: g = {7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F};
            6'd15: g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
            6'd16: g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
            6'd17: g = {7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E};
            6'd18: g = {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
            6'd19: g = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
            6'd20: g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
            6'd21: g = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
            6'd22: g = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
            6'd23: g = {7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F};
            6'd24: g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
            6'd25: g = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
            6'd26: g = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
            6'd27: g = {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
            6'd28: g = {7'h00, 7'h42, 7'h7F, 7'h40, 7'h00};
            6'd29: g = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
            6'd30: g = {7'h21, 7'h41, 7'h45, 7'h4B, 7'h31};
            6'd31: g = {7'h18, 7'h14, 7'h12, 7'h7F, 7'h10};
            6'd32: g = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
            6'd33: g = {7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30};
            6'd34: g = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
            6'd35: g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
            6'd36: g = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1E};
            default: g = '0;
        endcase
        // reorder so that column c sits at glyph[c]
        return {g[6:0], g[13:7], g[20:14], g[27:21], g[34:28]};
    endfunction

endpackage

// ----- src/tgr_front.sv -----
// ----------------------------------------------------------------------------
// tgr_front
// Accepts characters, tracks the cursor and looks up the glyph.
// ----------------------------------------------------------------------------
module tgr_front
    import tgr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CODE_W-1:0]  char_code,
    input  logic               start_flag,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    output logic               req_valid,
    input  logic               req_ready,
    output char_req_t          req
);

    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] col_use, row_use, col_adv;
    logic               accept;

    assign in_ready  = req_ready;
    assign req_valid = in_valid;
    assign accept    = in_valid && req_ready;

    always_comb begin
        col_use   = start_flag ? start_x : col_reg;
        row_use   = start_flag ? start_y : row_reg;
        col_adv   = col_use + ADVANCE;
        req.col   = col_use;
        req.row   = row_use;
        req.glyph = glyph_rom(glyph_index(char_code));
        col_next  = col_reg;
        row_next  = row_reg;
        if (accept) begin
            if (col_adv > COL_LIMIT) begin
                col_next = '0;
                row_next = row_use + LINE_STEP;
            end else begin
                col_next = col_adv;
                row_next = row_use;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ----- src/tgr_queue.sv -----
// ----------------------------------------------------------------------------
// tgr_queue
// Small request queue between the front and back parts.
// ----------------------------------------------------------------------------
module tgr_queue
    import tgr_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  char_req_t push_req,
    output logic      pop_valid,
    input  logic      pop_ready,
    output char_req_t pop_req
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    char_req_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != FULL_CNT);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_req    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- src/tgr_back.sv -----
// ----------------------------------------------------------------------------
// tgr_back
// Emits the window commands and pixel words of one character per request.
// ----------------------------------------------------------------------------
module tgr_back
    import tgr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [COLOR_W-1:0] ink_color,
    input  logic [COLOR_W-1:0] paper_color,
    input  logic               req_valid,
    output logic               req_ready,
    input  char_req_t          req,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_cmd,
    output logic [COLOR_W-1:0] out_word,
    output logic               out_last
);

    localparam int unsigned STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_CASET   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_X0      = 3'd1;
    localparam logic [STEP_W-1:0] STEP_X1      = 3'd2;
    localparam logic [STEP_W-1:0] STEP_RASET   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_Y0      = 3'd4;
    localparam logic [STEP_W-1:0] STEP_Y1      = 3'd5;
    localparam logic [STEP_W-1:0] STEP_RAMWR   = 3'd6;
    localparam logic [STEP_W-1:0] STEP_PIXELS  = 3'd7;
    localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);
    localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);

    logic [STEP_W-1:0]  step_reg, step_next;
    logic [2:0]         pcol_reg, pcol_next;
    logic [2:0]         prow_reg, prow_next;
    logic               valid_reg, valid_next;
    logic               cmd_reg, cmd_next;
    logic [COLOR_W-1:0] word_reg, word_next;
    logic               last_reg, last_next;
    logic               advance, final_pixel, pix_bit;

    assign out_valid   = valid_reg;
    assign out_cmd     = cmd_reg;
    assign out_word    = word_reg;
    assign out_last    = last_reg;
    assign advance     = req_valid && (!valid_reg || out_ready);
    assign final_pixel = (step_reg == STEP_PIXELS) && (pcol_reg == LAST_COL)
                         && (prow_reg == LAST_ROW);
    assign req_ready   = advance && final_pixel;
    assign pix_bit     = req.glyph[pcol_reg][prow_reg];

    always_comb begin
        step_next  = step_reg;
        pcol_next  = pcol_reg;
        prow_next  = prow_reg;
        valid_next = valid_reg && !out_ready;
        cmd_next   = cmd_reg;
        word_next  = word_reg;
        last_next  = last_reg;
        if (advance) begin
            valid_next = 1'b1;
            cmd_next   = 1'b0;
            last_next  = 1'b0;
            unique case (step_reg)
                STEP_CASET: begin
                    cmd_next  = 1'b1;
                    word_next = COLOR_W'(CMD_CASET);
                end
                STEP_X0:    word_next = COLOR_W'(req.col);
                // window ends keep only their low byte
                STEP_X1:    word_next = COLOR_W'(COORD_W'(req.col + WIN_WIDTH));
                STEP_RASET: begin
                    cmd_next  = 1'b1;
                    word_next = COLOR_W'(CMD_RASET);
                end
                STEP_Y0:    word_next = COLOR_W'(req.row);
                STEP_Y1:    word_next = COLOR_W'(COORD_W'(req.row + WIN_HEIGHT));
                STEP_RAMWR: begin
                    cmd_next  = 1'b1;
                    word_next = COLOR_W'(CMD_RAMWR);
                end
                default: begin
                    word_next = pix_bit ? ink_color : paper_color;
                    last_next = final_pixel;
                end
            endcase
            if (step_reg != STEP_PIXELS) begin
                step_next = step_reg + 1'b1;
            end else if (pcol_reg != LAST_COL) begin
                pcol_next = pcol_reg + 1'b1;
            end else begin
                pcol_next = '0;
                if (prow_reg != LAST_ROW) begin
                    prow_next = prow_reg + 1'b1;
                end else begin
                    // character done: rewind for the next request
                    prow_next = '0;
                    step_next = STEP_CASET;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= STEP_CASET;
            pcol_reg  <= '0;
            prow_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            pcol_reg  <= pcol_next;
            prow_reg  <= prow_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        word_reg <= word_next;
        last_reg <= last_next;
    end

endmodule

// ----- src/text_glyph_rasterizer.sv -----
// ----------------------------------------------------------------------------
// text_glyph_rasterizer
// 5x7 character generator producing panel window commands and RGB565 pixels.
// ----------------------------------------------------------------------------
// Each accepted character yields 42 output words, one per cycle while
// m_tready is high: CASET, x, x+4, RASET, y, y+6, RAMWR (tuser high on the
// three commands), then 35 pixel words row by row, tlast on the final one.
// The words leave through a single output register in the back end; the
// front end updates the cursor at intake and a short request queue lets
// new characters be taken while the current one is still being drawn.
// Colours must be written through the cfg port only while the block is
// idle; the block itself does not enforce this.
module text_glyph_rasterizer
    import tgr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // char_code[7:0], start_x[15:8], start_y[23:16]
    input  logic                 s_tuser,   // start_flag
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // word_value[15:0]
    output logic                 m_tuser,   // is_command
    output logic                 m_tlast    // last_word
);

    logic [COLOR_W-1:0] fg_reg, bg_reg;
    logic               push_valid, push_ready, pop_valid, pop_ready;
    char_req_t          push_req, pop_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= 16'hFFFF;
            bg_reg <= 16'h0000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FG_COLOR: fg_reg <= cfg_wdata;
                REG_BG_COLOR: bg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tgr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .char_code  (s_tdata[7:0]),
        .start_flag (s_tuser),
        .start_x    (s_tdata[15:8]),
        .start_y    (s_tdata[23:16]),
        .req_valid  (push_valid),
        .req_ready  (push_ready),
        .req        (push_req)
    );

    tgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req)
    );

    tgr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ink_color   (fg_reg),
        .paper_color (bg_reg),
        .req_valid   (pop_valid),
        .req_ready   (pop_ready),
        .req         (pop_req),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_cmd     (m_tuser),
        .out_word    (m_tdata),
        .out_last    (m_tlast)
    );

endmodule
